[rtl/core/alv_pkg.sv]
// shared types, character codes and limits for the array literal validator
`default_nettype none

package alv_pkg;

   localparam int MAX_LEN = 65536;
   localparam int POS_W   = $clog2(MAX_LEN + 1);
   localparam int CNT_W   = 15;
   localparam int IDX_W   = 16;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [POS_W-1:0] POS_MAX   = POS_W'(MAX_LEN);

   localparam logic [7:0] CH_COMMA     = 8'd44;
   localparam logic [7:0] CH_ZERO      = 8'd48;
   localparam logic [7:0] CH_NINE      = 8'd57;
   localparam logic [7:0] CH_QUOTE     = 8'd34;
   localparam logic [7:0] CH_BACKSLASH = 8'd92;
   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] CH_MINUS     = 8'd45;
   localparam logic [7:0] CH_OPEN      = 8'd91;
   localparam logic [7:0] CH_CLOSE     = 8'd93;

   typedef enum logic [6:0] {
      MODE_AWAIT  = 7'b0000001,
      MODE_SEP    = 7'b0000010,
      MODE_MINUS  = 7'b0000100,
      MODE_NUMBER = 7'b0001000,
      MODE_STRING = 7'b0010000,
      MODE_AFTER  = 7'b0100000,
      MODE_DEAD   = 7'b1000000
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FORMAT  = 2'd1,
      ST_INVALID = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef struct packed {
      mode_type           mode;
      logic               after_bs;
      logic [POS_W-1:0]   pos;
      logic [CNT_W-1:0]   comma_cnt;
      logic               open_ok;
      status_type         pend_status;
      logic [IDX_W-1:0]   pend_index;
      logic [7:0]         pend_char;
   } state_type;

   typedef struct packed {
      status_type         status;
      logic [CNT_W-1:0]   elem_count;
      logic [IDX_W-1:0]   err_index;
      logic [7:0]         err_char;
   } result_type;

   function automatic state_type reset_state();
      state_type s;
      s.mode        = MODE_AWAIT;
      s.after_bs    = 1'b0;
      s.pos         = '0;
      s.comma_cnt   = '0;
      s.open_ok     = 1'b0;
      s.pend_status = ST_OK;
      s.pend_index  = '0;
      s.pend_char   = '0;
      return s;
   endfunction

endpackage

`default_nettype wire

[rtl/core/array_literal_validator.sv]
// top level of the array literal validator: parse state and result register
//
// usage:
//   the literal enters one character per item on req_ch, req_last marking the
//   final character. an item is taken at a clock edge with req_valid high and
//   req_stall low; one item can be taken every cycle.
//   only the final item gives a result on the rsp_ channel: rsp_status,
//   rsp_elem_count, rsp_err_index and rsp_err_char. it appears in the cycle after
//   that item is taken and is taken when rsp_valid is high and rsp_stall low.
//   items that are not final give no result.
//   throughput is one character per cycle while req_stall is low; the parse
//   state register closes a loop through the mode update.
//   after a result the parse state is back at its start, so the next literal
//   may follow directly in the next cycle.
//   reset (synchronous, active high) clears the parse state and drops rsp_valid.
//   while a result waits under rsp_stall, req_stall is raised and no item is
//   taken; when the result is taken in a cycle a new item may enter as well.
`default_nettype none

module array_literal_validator (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_ch,
   input  wire logic                      req_last,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [alv_pkg::CNT_W-1:0]      rsp_elem_count,
   output logic [alv_pkg::IDX_W-1:0]      rsp_err_index,
   output logic [7:0]                     rsp_err_char
);

   alv_pkg::state_type  state_ff;
   alv_pkg::state_type  state_in;
   alv_pkg::result_type res_in;
   alv_pkg::result_type res_ff;
   logic                rsp_valid_ff;
   logic                accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   alv_step u_step (
      .cur  (state_ff),
      .ch   (req_ch),
      .last (req_last),
      .nxt  (state_in),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= alv_pkg::reset_state();
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept && req_last) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = res_ff.status;
   assign rsp_elem_count = res_ff.elem_count;
   assign rsp_err_index  = res_ff.err_index;
   assign rsp_err_char   = res_ff.err_char;

endmodule

`default_nettype wire

[rtl/core/alv_step.sv]
// next parse state and final result for one character of the literal
`default_nettype none

module alv_step (
   input  wire alv_pkg::state_type  cur,
   input  wire logic [7:0]          ch,
   input  wire logic                last,
   output alv_pkg::state_type       nxt,
   output alv_pkg::result_type      res
);

   logic is_digit;
   logic fmt_err;

   assign is_digit = (ch >= alv_pkg::CH_ZERO) && (ch <= alv_pkg::CH_NINE);
   assign fmt_err  = (cur.pos == '0) || !cur.open_ok || (ch != alv_pkg::CH_CLOSE) ||
                     (cur.pos >= alv_pkg::POS_MAX) || (cur.mode == alv_pkg::MODE_STRING);

   always_comb begin
      nxt = cur;
      if (cur.pos < alv_pkg::POS_MAX) begin
         nxt.pos = cur.pos + alv_pkg::POS_W'(1);
      end
      res.status     = alv_pkg::ST_OK;
      res.elem_count = '0;
      res.err_index  = '0;
      res.err_char   = '0;

      if (last) begin
         nxt = alv_pkg::reset_state();
         if (fmt_err) begin
            res.status = alv_pkg::ST_FORMAT;
         end else if (cur.pend_status != alv_pkg::ST_OK) begin
            res.status = cur.pend_status;
            if (cur.pend_status == alv_pkg::ST_INVALID) begin
               res.err_index = cur.pend_index;
               res.err_char  = cur.pend_char;
            end
         end else if (cur.mode == alv_pkg::MODE_SEP) begin
            if (cur.comma_cnt != '0) begin
               res.status = alv_pkg::ST_MISSING;
            end
         end else if (cur.mode == alv_pkg::MODE_MINUS) begin
            res.status    = alv_pkg::ST_INVALID;
            res.err_index = cur.pos[alv_pkg::IDX_W-1:0];
            res.err_char  = ch;
         end else if (cur.comma_cnt == alv_pkg::COUNT_MAX) begin
            res.elem_count = alv_pkg::COUNT_MAX;
         end else begin
            res.elem_count = cur.comma_cnt + alv_pkg::CNT_W'(1);
         end
      end else begin
         case (cur.mode)
            alv_pkg::MODE_AWAIT: begin
               nxt.open_ok = (ch == alv_pkg::CH_OPEN);
               nxt.mode    = (ch == alv_pkg::CH_OPEN) ? alv_pkg::MODE_SEP : alv_pkg::MODE_DEAD;
            end
            alv_pkg::MODE_SEP: begin
               if (ch == alv_pkg::CH_SPACE) begin
                  nxt.mode = alv_pkg::MODE_SEP;
               end else if (is_digit) begin
                  nxt.mode = alv_pkg::MODE_NUMBER;
               end else if (ch == alv_pkg::CH_MINUS) begin
                  nxt.mode = alv_pkg::MODE_MINUS;
               end else if (ch == alv_pkg::CH_QUOTE) begin
                  nxt.mode     = alv_pkg::MODE_STRING;
                  nxt.after_bs = 1'b0;
               end else if (ch == alv_pkg::CH_COMMA) begin
                  nxt.pend_status = alv_pkg::ST_MISSING;
                  nxt.mode        = alv_pkg::MODE_DEAD;
               end else begin
                  nxt.pend_status = alv_pkg::ST_INVALID;
                  nxt.pend_index  = cur.pos[alv_pkg::IDX_W-1:0];
                  nxt.pend_char   = ch;
                  nxt.mode        = alv_pkg::MODE_DEAD;
               end
            end
            alv_pkg::MODE_MINUS: begin
               if (is_digit) begin
                  nxt.mode = alv_pkg::MODE_NUMBER;
               end else begin
                  nxt.pend_status = alv_pkg::ST_INVALID;
                  nxt.pend_index  = cur.pos[alv_pkg::IDX_W-1:0];
                  nxt.pend_char   = ch;
                  nxt.mode        = alv_pkg::MODE_DEAD;
               end
            end
            alv_pkg::MODE_NUMBER, alv_pkg::MODE_AFTER: begin
               if (is_digit && (cur.mode == alv_pkg::MODE_NUMBER)) begin
                  nxt.mode = alv_pkg::MODE_NUMBER;
               end else if (ch == alv_pkg::CH_SPACE) begin
                  nxt.mode = alv_pkg::MODE_AFTER;
               end else if (ch == alv_pkg::CH_COMMA) begin
                  if (cur.comma_cnt != alv_pkg::COUNT_MAX) begin
                     nxt.comma_cnt = cur.comma_cnt + alv_pkg::CNT_W'(1);
                  end
                  nxt.mode = alv_pkg::MODE_SEP;
               end else begin
                  nxt.pend_status = alv_pkg::ST_INVALID;
                  nxt.pend_index  = cur.pos[alv_pkg::IDX_W-1:0];
                  nxt.pend_char   = ch;
                  nxt.mode        = alv_pkg::MODE_DEAD;
               end
            end
            alv_pkg::MODE_STRING: begin
               if ((ch == alv_pkg::CH_QUOTE) && !cur.after_bs) begin
                  nxt.mode = alv_pkg::MODE_AFTER;
               end
               nxt.after_bs = (ch == alv_pkg::CH_BACKSLASH);
            end
            default: begin
               nxt.mode = cur.mode;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for array_literal_validator: random and directed literals
`default_nettype none

module testbench;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;
   localparam int ITEM_TOTAL  = 950;

   typedef logic [7:0] char_list_type [$];

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_ch = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_status;
   logic [alv_pkg::CNT_W-1:0] rsp_elem_count;
   logic [alv_pkg::IDX_W-1:0] rsp_err_index;
   logic [7:0]                rsp_err_char;

   char_item_type       pending_chars [$];
   alv_pkg::result_type expected_verdicts [$];
   alv_pkg::result_type seen_verdict;
   char_item_type       next_char;

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int   error_count = 0;
   int   quiet_cycles = 0;
   int   send_wait = 0;
   int   recv_wait = 0;
   int   hold_left = 0;
   int   results_taken = 0;
   bit   send_busy = 1'b0;
   bit   recv_busy = 1'b0;

   // literal parser state
   alv_pkg::mode_type         lit_mode;
   logic                      lit_escape;
   logic [alv_pkg::POS_W-1:0] lit_pos;
   logic [alv_pkg::CNT_W-1:0] lit_commas;
   logic                      lit_opened;
   alv_pkg::status_type       lit_err_status;
   logic [alv_pkg::IDX_W-1:0] lit_err_index;
   logic [7:0]                lit_err_char;

   array_literal_validator uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_ch         (req_ch),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_elem_count (rsp_elem_count),
      .rsp_err_index  (rsp_err_index),
      .rsp_err_char   (rsp_err_char)
   );

   always #5 clock = ~clock;

   task automatic clear_literal();
      lit_mode       = alv_pkg::MODE_AWAIT;
      lit_escape     = 1'b0;
      lit_pos        = '0;
      lit_commas     = '0;
      lit_opened     = 1'b0;
      lit_err_status = alv_pkg::ST_OK;
      lit_err_index  = '0;
      lit_err_char   = '0;
   endtask

   function automatic bit is_digit(logic [7:0] c);
      return c >= alv_pkg::CH_ZERO && c <= alv_pkg::CH_NINE;
   endfunction

   task automatic mark_invalid(input logic [alv_pkg::POS_W-1:0] at, input logic [7:0] c);
      lit_err_status = alv_pkg::ST_INVALID;
      lit_err_index  = at[alv_pkg::IDX_W-1:0];
      lit_err_char   = c;
      lit_mode       = alv_pkg::MODE_DEAD;
   endtask

   task automatic note_comma();
      if (lit_commas != alv_pkg::COUNT_MAX) lit_commas = lit_commas + alv_pkg::CNT_W'(1);
      lit_mode = alv_pkg::MODE_SEP;
   endtask

   task automatic scan_interior(input logic [alv_pkg::POS_W-1:0] at, input logic [7:0] c);
      case (lit_mode)
         alv_pkg::MODE_SEP: begin
            if (c == alv_pkg::CH_SPACE) begin
            end else if (is_digit(c)) begin
               lit_mode = alv_pkg::MODE_NUMBER;
            end else if (c == alv_pkg::CH_MINUS) begin
               lit_mode = alv_pkg::MODE_MINUS;
            end else if (c == alv_pkg::CH_QUOTE) begin
               lit_mode   = alv_pkg::MODE_STRING;
               lit_escape = 1'b0;
            end else if (c == alv_pkg::CH_COMMA) begin
               lit_err_status = alv_pkg::ST_MISSING;
               lit_mode       = alv_pkg::MODE_DEAD;
            end else begin
               mark_invalid(at, c);
            end
         end
         alv_pkg::MODE_MINUS: begin
            if (is_digit(c)) lit_mode = alv_pkg::MODE_NUMBER;
            else mark_invalid(at, c);
         end
         alv_pkg::MODE_NUMBER: begin
            if (is_digit(c)) begin
            end else if (c == alv_pkg::CH_SPACE) begin
               lit_mode = alv_pkg::MODE_AFTER;
            end else if (c == alv_pkg::CH_COMMA) begin
               note_comma();
            end else begin
               mark_invalid(at, c);
            end
         end
         alv_pkg::MODE_STRING: begin
            if (c == alv_pkg::CH_QUOTE && !lit_escape) lit_mode = alv_pkg::MODE_AFTER;
            lit_escape = (c == alv_pkg::CH_BACKSLASH);
         end
         alv_pkg::MODE_AFTER: begin
            if (c == alv_pkg::CH_SPACE) begin
            end else if (c == alv_pkg::CH_COMMA) begin
               note_comma();
            end else begin
               mark_invalid(at, c);
            end
         end
         default: begin
         end
      endcase
   endtask

   // one accepted character; the final one yields the expected verdict
   task automatic parse_char(input logic [7:0] c, input logic fin);
      logic [alv_pkg::POS_W-1:0] at;
      alv_pkg::result_type       v;
      at = lit_pos;
      if (lit_pos < alv_pkg::POS_MAX) lit_pos = lit_pos + alv_pkg::POS_W'(1);
      if (!fin) begin
         if (lit_mode == alv_pkg::MODE_AWAIT) begin
            lit_opened = (c == alv_pkg::CH_OPEN);
            lit_mode   = lit_opened ? alv_pkg::MODE_SEP : alv_pkg::MODE_DEAD;
         end else begin
            scan_interior(at, c);
         end
      end else begin
         v        = '0;
         v.status = alv_pkg::ST_OK;
         if (at == 0 || !lit_opened || c != alv_pkg::CH_CLOSE || at >= alv_pkg::POS_MAX ||
             lit_mode == alv_pkg::MODE_STRING) begin
            v.status = alv_pkg::ST_FORMAT;
         end else if (lit_err_status != alv_pkg::ST_OK) begin
            v.status = lit_err_status;
            if (v.status == alv_pkg::ST_INVALID) begin
               v.err_index = lit_err_index;
               v.err_char  = lit_err_char;
            end
         end else if (lit_mode == alv_pkg::MODE_SEP) begin
            if (lit_commas != 0) v.status = alv_pkg::ST_MISSING;
         end else if (lit_mode == alv_pkg::MODE_MINUS) begin
            v.status    = alv_pkg::ST_INVALID;
            v.err_index = at[alv_pkg::IDX_W-1:0];
            v.err_char  = c;
         end else begin
            v.elem_count = (lit_commas == alv_pkg::COUNT_MAX) ? alv_pkg::COUNT_MAX :
                           lit_commas + alv_pkg::CNT_W'(1);
         end
         expected_verdicts.push_back(v);
         clear_literal();
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   function automatic int draw_wait(bit busy);
      if (busy) return $urandom_range(0, 16);
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
   endfunction

   task automatic queue_literal(input char_list_type text);
      char_item_type it;
      foreach (text[i]) begin
         it.ch   = text[i];
         it.last = (i == text.size() - 1);
         pending_chars.push_back(it);
      end
   endtask

   task automatic queue_text(input string s);
      char_list_type text;
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      queue_literal(text);
   endtask

   task automatic add_spaces(ref char_list_type text);
      repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
         text.push_back(alv_pkg::CH_SPACE);
   endtask

   task automatic queue_random_literal();
      char_list_type text;
      logic [7:0]    odd_chars [8];
      logic [7:0]    c;
      int            n_elem;
      int            spot;
      odd_chars = '{alv_pkg::CH_MINUS, alv_pkg::CH_COMMA, alv_pkg::CH_QUOTE,
                    alv_pkg::CH_BACKSLASH, alv_pkg::CH_OPEN, alv_pkg::CH_CLOSE,
                    alv_pkg::CH_SPACE, alv_pkg::CH_ZERO};
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 8)) text.push_back(8'($urandom));
      end else begin
         text.push_back(alv_pkg::CH_OPEN);
         add_spaces(text);
         n_elem = $urandom_range(0, 6);
         for (int e = 0; e < n_elem; e++) begin
            if (e > 0) begin
               text.push_back(alv_pkg::CH_COMMA);
               add_spaces(text);
            end
            if ($urandom_range(0, 1) == 0) begin
               if ($urandom_range(0, 3) == 0) text.push_back(alv_pkg::CH_MINUS);
               repeat ($urandom_range(1, 4))
                  text.push_back(8'(alv_pkg::CH_ZERO + $urandom_range(0, 9)));
            end else begin
               text.push_back(alv_pkg::CH_QUOTE);
               repeat ($urandom_range(0, 5)) begin
                  c = 8'($urandom);
                  if (c == alv_pkg::CH_QUOTE) text.push_back(alv_pkg::CH_BACKSLASH);
                  text.push_back(c);
               end
               if (text[$] == alv_pkg::CH_BACKSLASH) text.push_back(alv_pkg::CH_ZERO);
               text.push_back(alv_pkg::CH_QUOTE);
            end
            add_spaces(text);
         end
         if ($urandom_range(0, 7) == 0) begin
            text.push_back(alv_pkg::CH_COMMA);
            add_spaces(text);
         end
         text.push_back(alv_pkg::CH_CLOSE);
         if ($urandom_range(0, 3) == 0) begin
            spot = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 3))
               0: text[spot] = 8'($urandom);
               1: text.insert(spot, odd_chars[$urandom_range(0, 7)]);
               2: if (text.size() > 1) text.delete(spot);
               default: if (text.size() > 1) text.delete(text.size() - 1);
            endcase
         end
      end
      queue_literal(text);
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (pending_chars.size() != 0) begin
            next_char = pending_chars.pop_front();
            req_ch    <= next_char.ch;
            req_last  <= next_char.last;
            req_valid <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_busy = !send_busy;
            send_wait = draw_wait(send_busy);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_fire) begin
            results_taken++;
            if (results_taken == 30 || results_taken == 300) hold_left = HOLD_CYCLES;
            if ($urandom_range(0, 39) == 0) recv_busy = !recv_busy;
            recv_wait = draw_wait(recv_busy);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("unexpected result: status %0d", rsp_status);
               error_count++;
            end else begin
               seen_verdict = expected_verdicts.pop_front();
               check_field("status", 16'(seen_verdict.status), 16'(rsp_status));
               check_field("elem_count", 16'(seen_verdict.elem_count), 16'(rsp_elem_count));
               check_field("err_index", seen_verdict.err_index, rsp_err_index);
               check_field("err_char", 16'(seen_verdict.err_char), 16'(rsp_err_char));
            end
         end
         if (req_valid && !req_stall) parse_char(req_ch, req_last);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   initial begin
      clear_literal();

      queue_text("[]");
      queue_text("[   ]");
      queue_text("[1,-23, \"a\\\"b\" ]");
      queue_text("[ 007 , \"\" , -0]");
      queue_text("[1,]");
      queue_text("[1 ,  ]");
      queue_text("[1, , 2]");
      queue_text("[,1]");
      queue_text("[1 2]");
      queue_text("[-a]");
      queue_text("[-]");
      queue_text("[1-]");
      queue_text("[1,2");
      queue_text("x1]");
      queue_text("]");
      queue_text("[");
      queue_text("[\"abc]");
      queue_text("[\"a\\\\\"]");
      queue_text("[[1]]");
      queue_text("[1]]");
      queue_text("[1,,a]");
      queue_text("[\"a\"b]");
      queue_text("[1, q, [");
      queue_literal('{alv_pkg::CH_OPEN, 8'hFF, alv_pkg::CH_CLOSE});
      queue_literal('{alv_pkg::CH_OPEN, alv_pkg::CH_QUOTE, 8'h00, 8'hFF,
                      alv_pkg::CH_QUOTE, alv_pkg::CH_CLOSE});

      while (pending_chars.size() < ITEM_TOTAL) queue_random_literal();

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_chars.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (expected_verdicts.size() != 0) $error("%0d results missing", expected_verdicts.size());
      if (error_count == 0 && expected_verdicts.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
